### hw/rtl/qaps_pkg.sv
package qaps_pkg;

  localparam int MAX_PATTERN_DEF    = 8;
  localparam int POSITION_WIDTH_DEF = 16;

  localparam int CHAR_W    = 8;
  localparam int PATTERN_W = 64;
  localparam int LEN_W     = 4;
  localparam int START_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_DQUOTE    = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SQUOTE    = 8'h27;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUOTE_BYPASS   = 2'd2;

  typedef enum logic [1:0] {
    ST_SEARCHING = 2'd0,
    ST_MATCH_NOW = 2'd1,
    ST_MATCHED   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

### hw/rtl/qaps_in_if.sv
interface qaps_in_if import qaps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_char;
  logic              last_char_flag;

  modport source (output valid, text_char, last_char_flag, input ready);
  modport sink   (input valid, text_char, last_char_flag, output ready);
endinterface

### hw/rtl/qaps_out_if.sv
interface qaps_out_if import qaps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         search_status;
  logic [START_W-1:0] match_start;

  modport source (output valid, search_status, match_start, input ready);
  modport sink   (input valid, search_status, match_start, output ready);
endinterface

### hw/rtl/qaps_cfg_if.sv
interface qaps_cfg_if import qaps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [PATTERN_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### hw/rtl/qaps_window_cmp.sv
module qaps_window_cmp import qaps_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic [MAX_PATTERN-1:0][CHAR_W-1:0] window,
  input  logic [MAX_PATTERN-1:0]             start_ok,
  input  logic [PATTERN_W-1:0]               pattern,
  input  logic [LEN_W-1:0]                   len,
  output logic                               hit
);

  localparam int IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PadN = 1 << IdxW;

  logic [PadN-1:0][CHAR_W-1:0] win_pad;
  logic [PadN-1:0]             ok_pad;
  logic [LEN_W-1:0]            len_m1;
  logic                        all_eq;

  always_comb begin
    win_pad = '0;
    ok_pad  = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      win_pad[j] = window[j];
      ok_pad[j]  = start_ok[j];
    end
  end

  assign len_m1 = len - LEN_W'(1);

  // byte i of the pattern lines up with the character len-1-i back
  always_comb begin
    logic [LEN_W-1:0] back;
    all_eq = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      back = len_m1 - LEN_W'(i);
      if (LEN_W'(i) < len &&
          win_pad[back[IdxW-1:0]] != pattern[CHAR_W*i +: CHAR_W]) begin
        all_eq = 1'b0;
      end
    end
  end

  assign hit = (len != '0) && ok_pad[len_m1[IdxW-1:0]] && all_eq;

endmodule

### hw/rtl/quote_aware_pattern_seek.sv
// A result item is registered and valid in the cycle after its input item is accepted.
// Throughput: one item per cycle while the output is not stalled; window compare, escape
// and quote tracking are all combinational between the search state and the result register.
// in_ch.ready stays high while the result register is empty or being taken.
// Reset (synchronous, rst_n low) clears the search state and result valid,
// and sets pattern_bytes to 0, pattern_length to 1 and the quote bypass to 0.
module quote_aware_pattern_seek import qaps_pkg::*; #(
  parameter int MAX_PATTERN    = MAX_PATTERN_DEF,
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  qaps_in_if.sink    in_ch,
  qaps_out_if.source out_ch,
  qaps_cfg_if.sink   cfg_ch
);

  localparam int RecentDepth = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_PATTERN);

  // configuration
  logic [PATTERN_W-1:0] pattern_r;
  logic [LEN_W-1:0]     plen_r;
  logic                 ign_r;

  // search state
  logic [RecentDepth-1:0][CHAR_W-1:0] recent_r, recent_nxt;
  logic [MAX_PATTERN-1:0]             flags_r, flags_nxt;
  logic                               esc_r, esc_nxt;
  logic [CHAR_W-1:0]                  prev_r, prev_nxt;
  logic                               inq_r, inq_nxt;
  logic [CHAR_W-1:0]                  oq_r, oq_nxt;
  logic [POSITION_WIDTH-1:0]          idx_r, idx_nxt;
  logic                               done_r, done_nxt;

  // result register
  logic                      out_valid_r;
  status_t                   status_r, status_nxt;
  logic [START_W-1:0]        start_r, start_nxt;

  logic                                accept;
  logic [CHAR_W-1:0]                   c;
  logic                                last;
  logic [LEN_W-1:0]                    len;
  logic                                allowed;
  logic [MAX_PATTERN:0]                flags_cat;
  logic [MAX_PATTERN-1:0]              flags_shift;
  logic [MAX_PATTERN-1:0][CHAR_W-1:0]  window;
  logic                                hit;
  logic                                sat;
  logic [POSITION_WIDTH-1:0]           pos_val;
  logic [POSITION_WIDTH+START_W-1:0]   pos_ext;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign c            = in_ch.text_char;
  assign last         = in_ch.last_char_flag;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.search_status = status_r;
  assign out_ch.match_start   = start_r;

  assign len         = (plen_r > MaxLen) ? MaxLen : plen_r;
  assign allowed     = !esc_r && (ign_r || !inq_r);
  assign flags_cat   = {flags_r, allowed};
  assign flags_shift = flags_cat[MAX_PATTERN-1:0];
  assign sat         = (idx_r == '1);

  always_comb begin
    window[0] = c;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      window[j] = recent_r[j-1];
    end
  end

  qaps_window_cmp #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_window_cmp (
    .window   (window),
    .start_ok (flags_shift),
    .pattern  (pattern_r),
    .len      (len),
    .hit      (hit)
  );

  always_comb begin
    recent_nxt = recent_r;
    flags_nxt  = flags_r;
    esc_nxt    = esc_r;
    prev_nxt   = prev_r;
    inq_nxt    = inq_r;
    oq_nxt     = oq_r;
    idx_nxt    = idx_r;
    done_nxt   = done_r;
    status_nxt = ST_SEARCHING;
    pos_val    = '0;

    if (done_r) begin
      status_nxt = ST_MATCHED;
      pos_val    = idx_r;
    end else begin
      flags_nxt = flags_shift;
      if (hit) begin
        status_nxt = ST_MATCH_NOW;
        pos_val    = sat ? '1
                         : idx_r - POSITION_WIDTH'(len) + POSITION_WIDTH'(1);
        done_nxt   = 1'b1;
        idx_nxt    = pos_val;
      end else begin
        if (!ign_r && !esc_r && (c == CH_DQUOTE || c == CH_SQUOTE)) begin
          if (inq_r && oq_r == c) begin
            inq_nxt = 1'b0;
            oq_nxt  = '0;
          end else begin
            inq_nxt = 1'b1;
            oq_nxt  = c;
          end
        end
        esc_nxt  = (c == CH_BACKSLASH) && (prev_r != CH_BACKSLASH);
        prev_nxt = c;
        recent_nxt[0] = c;
        for (int j = 1; j < RecentDepth; j++) begin
          recent_nxt[j] = recent_r[j-1];
        end
        if (last) begin
          status_nxt = ST_NOT_FOUND;
          pos_val    = sat ? '1 : idx_r + POSITION_WIDTH'(1);
        end else if (!sat) begin
          idx_nxt = idx_r + POSITION_WIDTH'(1);
        end
      end
    end

    // end of string: drop all search state
    if (last) begin
      recent_nxt = '0;
      flags_nxt  = '0;
      esc_nxt    = 1'b0;
      prev_nxt   = '0;
      inq_nxt    = 1'b0;
      oq_nxt     = '0;
      idx_nxt    = '0;
      done_nxt   = 1'b0;
    end
  end

  assign pos_ext   = {{START_W{1'b0}}, pos_val};
  assign start_nxt = pos_ext[START_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      plen_r    <= LEN_W'(1);
      ign_r     <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.reg_index)
        REG_PATTERN_BYTES:  pattern_r <= cfg_ch.wdata;
        REG_PATTERN_LENGTH: plen_r    <= cfg_ch.wdata[LEN_W-1:0];
        REG_QUOTE_BYPASS:   ign_r     <= cfg_ch.wdata[0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r <= '0;
      flags_r  <= '0;
      esc_r    <= 1'b0;
      prev_r   <= '0;
      inq_r    <= 1'b0;
      oq_r     <= '0;
      idx_r    <= '0;
      done_r   <= 1'b0;
    end else if (accept) begin
      recent_r <= recent_nxt;
      flags_r  <= flags_nxt;
      esc_r    <= esc_nxt;
      prev_r   <= prev_nxt;
      inq_r    <= inq_nxt;
      oq_r     <= oq_nxt;
      idx_r    <= idx_nxt;
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      start_r  <= start_nxt;
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item produced no result");

  a_match_latches: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !done_r && hit && !last) |=> (done_r && status_r == ST_MATCH_NOW))
    else $error("match not recorded");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last) |=> (!done_r && idx_r == '0 && flags_r == '0 && !inq_r))
    else $error("search state not cleared after last item");

  a_matched_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && done_r && !last) |=> (done_r && $stable(idx_r) && $stable(inq_r)))
    else $error("state changed after match");

endmodule
